// ===== hdl/srsw_pkg.sv =====
// Shared types and constants for the selective-repeat sender window.
package srsw_pkg;

    // Fixed field widths
    localparam int REF_W       = 16;
    localparam int CMD_W       = 2;
    localparam int FRAME_OUT_W = 8;
    localparam int TOTAL_W     = 9;
    localparam int TIMEOUT_W   = 16;
    localparam int IDLE_W      = 16;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int OUT_USER_W  = 2;

    // Configuration reset values
    localparam logic [TOTAL_W-1:0]   TOTAL_RESET   = 9'd10;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd30;
    localparam logic                 NACK_EN_RESET = 1'b0;

    // Request kinds
    localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ACK  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_NACK = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_TOTAL   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_TIMEOUT = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_NACK_EN = 2'd2;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_NEW,
        S_CMD,
        S_SLIDE,
        S_EMIT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic new_frames;
        logic handle;
        logic slide;
        logic emit;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic can_slide;
        logic has_pick;
    } t_dp_status;

endpackage

// ===== hdl/srsw_ctrl.sv =====
// Sequencer that steps one request through new-frame, handling, slide and emit phases.
module srsw_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    input  srsw_pkg::t_dp_status i_status,
    output logic                 o_s_tready,
    output srsw_pkg::t_dp_cmd    o_cmd
);
    import srsw_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = S_NEW;
                end
            end
            S_NEW:   n_state = S_CMD;
            S_CMD:   n_state = S_SLIDE;
            S_SLIDE: begin
                if (!i_status.can_slide) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!i_status.has_pick) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_s_tready       = (r_state == S_IDLE);
        o_cmd.load       = (r_state == S_IDLE) && i_s_tvalid;
        o_cmd.new_frames = (r_state == S_NEW);
        o_cmd.handle     = (r_state == S_CMD);
        o_cmd.slide      = (r_state == S_SLIDE) && i_status.can_slide;
        o_cmd.emit       = (r_state == S_EMIT);
    end

endmodule

// ===== hdl/srsw_dp.sv =====
// Window state, configuration registers, request handling and result register.
module srsw_dp #(
    parameter int WINDOW     = 4,
    parameter int MAX_FRAMES = 256
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [srsw_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [srsw_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  srsw_pkg::t_dp_cmd                   i_cmd,
    input  logic [srsw_pkg::REF_W-1:0]          i_s_tdata,
    input  logic [srsw_pkg::CMD_W-1:0]          i_s_tuser,
    output srsw_pkg::t_dp_status                o_status,
    input  logic                                i_m_tready,
    output logic                                o_m_tvalid,
    output logic [srsw_pkg::FRAME_OUT_W-1:0]    o_m_tdata,
    output logic [srsw_pkg::OUT_USER_W-1:0]     o_m_tuser,
    output logic                                o_m_tlast
);
    import srsw_pkg::*;

    localparam int FW = $clog2(MAX_FRAMES + 1);
    localparam int XW = FW + 1;
    localparam int IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CW = (XW > TOTAL_W) ? XW : TOTAL_W;

    // Configuration
    logic [TOTAL_W-1:0]   r_total;
    logic [TIMEOUT_W-1:0] r_timeout;
    logic                 r_nack_en;

    // Window state
    logic [FW-1:0]     r_base;
    logic [FW-1:0]     r_next;
    logic [WINDOW-1:0] r_acked;     // bit j: frame base+j acknowledged
    logic [IDLE_W-1:0] r_idle;

    // Request in flight
    logic [CMD_W-1:0]  r_kind;
    logic [REF_W-1:0]  r_ref;
    logic [FW-1:0]     r_emit_ptr;
    logic [WINDOW-1:0] r_res_mask;  // bit j: resend frame base+j
    logic              r_nack_pend;
    logic [FW-1:0]     r_nack_frame;

    // Result register
    logic                   r_out_valid;
    logic [FRAME_OUT_W-1:0] r_out_frame;
    logic                   r_out_resend;
    logic                   r_out_last;
    logic                   r_out_done;

    logic [FW-1:0]     w_total;
    logic [XW-1:0]     w_win_end;
    logic [XW-1:0]     w_lim;
    logic              w_has_new;
    logic [IDLE_W-1:0] w_idle_inc;
    logic              w_fire;
    logic [FW-1:0]     w_out_cnt;
    logic [WINDOW-1:0] w_tick_mask;
    logic              w_ack_ok;
    logic [IW-1:0]     w_ack_off;
    logic              w_nack_ok;
    logic              w_can_slide;
    logic              w_new_left;
    logic              w_mask_any;
    logic [WINDOW-1:0] w_low_bit;
    logic [WINDOW-1:0] w_rest_mask;
    logic [IW-1:0]     w_low_idx;
    logic              w_has_pick;
    logic [FW-1:0]     w_pick_frame;
    logic              w_pick_last;
    logic              w_out_load;

    // Effective frame count, clamped to the storage range
    always_comb begin
        w_total = (CW'(r_total) > CW'(MAX_FRAMES)) ? FW'(MAX_FRAMES) : FW'(r_total);
    end

    // New-frame limit: min(base + WINDOW, total)
    always_comb begin
        w_win_end = XW'(r_base) + XW'(WINDOW);
        w_lim     = (w_win_end < XW'(w_total)) ? w_win_end : XW'(w_total);
        w_has_new = XW'(r_next) < w_lim;
    end

    // Request handling terms (next already holds the post-emission value)
    always_comb begin
        w_idle_inc = (r_idle == '1) ? r_idle : r_idle + 1'b1;
        w_fire     = (w_idle_inc > r_timeout) && (r_base < r_next);
        w_out_cnt  = r_next - r_base;
        for (int j = 0; j < WINDOW; j++) begin
            w_tick_mask[j] = (j < int'(w_out_cnt)) && !r_acked[j];
        end
        w_ack_ok  = (r_ref < REF_W'(w_total)) && (r_ref < REF_W'(r_next))
                    && (r_ref >= REF_W'(r_base));
        w_ack_off = IW'(r_ref - REF_W'(r_base));
        w_nack_ok = r_nack_en && (r_ref >= REF_W'(r_base)) && (r_ref < REF_W'(r_next));
    end

    // Base slides over acknowledged frames one per cycle
    assign w_can_slide = (r_base < w_total) && r_acked[0];

    // Result selection: new frames, then timeout resends, then the nack resend
    always_comb begin
        w_new_left  = (r_emit_ptr != r_next);
        w_mask_any  = |r_res_mask;
        w_low_bit   = r_res_mask & (~r_res_mask + 1'b1);
        w_rest_mask = r_res_mask & ~w_low_bit;
        w_low_idx   = '0;
        for (int j = WINDOW - 1; j >= 0; j--) begin
            if (r_res_mask[j]) begin
                w_low_idx = IW'(j);
            end
        end
        w_has_pick = w_new_left || w_mask_any || r_nack_pend;
        if (w_new_left) begin
            w_pick_frame = r_emit_ptr;
            w_pick_last  = ((r_emit_ptr + 1'b1) == r_next) && !w_mask_any && !r_nack_pend;
        end else if (w_mask_any) begin
            w_pick_frame = r_base + FW'(w_low_idx);
            w_pick_last  = !(|w_rest_mask) && !r_nack_pend;
        end else begin
            w_pick_frame = r_nack_frame;
            w_pick_last  = 1'b1;
        end
        w_out_load = i_cmd.emit && w_has_pick && (!r_out_valid || i_m_tready);
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total   <= TOTAL_RESET;
            r_timeout <= TIMEOUT_RESET;
            r_nack_en <= NACK_EN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_TOTAL:   r_total   <= i_cfg_wdata[TOTAL_W-1:0];
                CFG_TIMEOUT: r_timeout <= i_cfg_wdata[TIMEOUT_W-1:0];
                CFG_NACK_EN: r_nack_en <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Captured request payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_s_tuser;
            r_ref  <= i_s_tdata;
        end
    end

    // Window state and resend bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= '0;
            r_next      <= '0;
            r_acked     <= '0;
            r_idle      <= '0;
            r_emit_ptr  <= '0;
            r_res_mask  <= '0;
            r_nack_pend <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_res_mask  <= '0;
                r_nack_pend <= 1'b0;
            end
            if (i_cmd.new_frames) begin
                r_emit_ptr <= r_next;
                if (w_has_new) begin
                    r_next <= w_lim[FW-1:0];
                    r_idle <= '0;
                end
            end
            if (i_cmd.handle) begin
                case (r_kind)
                    CMD_TICK: begin
                        r_idle <= w_fire ? '0 : w_idle_inc;
                        if (w_fire) begin
                            r_res_mask <= w_tick_mask;
                        end
                    end
                    CMD_ACK: begin
                        if (w_ack_ok) begin
                            r_acked[w_ack_off] <= 1'b1;
                        end
                    end
                    CMD_NACK: begin
                        if (w_nack_ok) begin
                            r_nack_pend <= 1'b1;
                            r_idle      <= '0;
                        end
                    end
                    default: ;
                endcase
            end
            if (i_cmd.slide) begin
                r_base  <= r_base + 1'b1;
                r_acked <= r_acked >> 1;
            end
            if (w_out_load) begin
                if (w_new_left) begin
                    r_emit_ptr <= r_emit_ptr + 1'b1;
                end else if (w_mask_any) begin
                    r_res_mask <= w_rest_mask;
                end else begin
                    r_nack_pend <= 1'b0;
                end
            end
        end
    end

    // Nack frame number, in range once accepted
    always_ff @(posedge i_clk) begin
        if (i_cmd.handle) begin
            r_nack_frame <= FW'(r_ref);
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_frame  <= FRAME_OUT_W'(w_pick_frame);
            r_out_resend <= !w_new_left;
            r_out_last   <= w_pick_last;
            r_out_done   <= (r_base >= w_total);
        end
    end

    assign o_status.can_slide = w_can_slide;
    assign o_status.has_pick  = w_has_pick;
    assign o_m_tvalid         = r_out_valid;
    assign o_m_tdata          = r_out_frame;
    assign o_m_tuser          = {r_out_done, r_out_resend};
    assign o_m_tlast          = r_out_last;

endmodule

// ===== hdl/selective_repeat_sender_window_unit.sv =====
// Selective-repeat ARQ sender window: sends new frames, tracks acks, resends on timeout or nack.
// Each request (tick, ack or nack) is accepted in idle and then passes the new-frame, handling,
// base-slide and emit states; the slide state steps the base over acknowledged frames one per
// cycle and the emit state loads one result per cycle while the result side keeps up, waiting
// while it stalls. Base steps and results of one request together number at most 2 * WINDOW (a
// tick with a zero timeout after a full window of new frames).
// Results of a request are emitted after the request is fully handled, so all_done reflects
// the window base at the end of the request. One result register decouples the result side;
// the next request is taken while the last result still waits. The user must write configuration
// only while the block is idle; the block itself does not enforce this. There is no read-back.
module selective_repeat_sender_window_unit #(
    parameter int WINDOW     = 4,
    parameter int MAX_FRAMES = 256
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [srsw_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [srsw_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [srsw_pkg::REF_W-1:0]       i_s_tdata,   // [15:0] frame_ref
    input  logic [srsw_pkg::CMD_W-1:0]       i_s_tuser,   // [1:0] cmd
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [srsw_pkg::FRAME_OUT_W-1:0] o_m_tdata,   // [7:0] frame_number
    output logic [srsw_pkg::OUT_USER_W-1:0]  o_m_tuser,   // [0] is_resend, [1] all_done
    output logic                             o_m_tlast
);
    import srsw_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    srsw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_status   (w_status),
        .o_s_tready (o_s_tready),
        .o_cmd      (w_cmd)
    );

    srsw_dp #(
        .WINDOW     (WINDOW),
        .MAX_FRAMES (MAX_FRAMES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (w_cmd),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_status    (w_status),
        .i_m_tready  (i_m_tready),
        .o_m_tvalid  (o_m_tvalid),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

endmodule

// ===== hdl/srsw_chk.sv =====
// Port-level checker for the sender window, bound to the top level.
module srsw_chk (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_s_tvalid,
    input logic                             o_s_tready,
    input logic                             o_m_tvalid,
    input logic                             i_m_tready,
    input logic [srsw_pkg::FRAME_OUT_W-1:0] o_m_tdata,
    input logic [srsw_pkg::OUT_USER_W-1:0]  o_m_tuser,
    input logic                             o_m_tlast
);

    // A stalled result holds its contents
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=>
            o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("result changed while stalled");

    // A request is worked on before the next is taken: ready drops once a request is accepted
    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("request taken in consecutive cycles");

    // While a request still has results to deliver, no new request is taken
    a_no_take_mid_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tlast |-> !o_s_tready)
        else $error("request taken before prior results finished");

    // After a request is taken, the results of the previous one stay ordered: no new result
    // appears in the cycle right after acceptance
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && !o_m_tvalid |=> !o_m_tvalid)
        else $error("result produced without handling time");

endmodule

bind selective_repeat_sender_window_unit srsw_chk u_srsw_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);
